// ----- hw/rtl/ewfs_pkg.sv -----
`default_nettype none

package ewfs_pkg;

	localparam int TIME_W = 48;
	localparam int DUR_W  = 32;
	localparam int ID_W   = 4;
	localparam int CFG_W  = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/earliest_free_worker_scheduler.sv -----
`default_nettype none

// Earliest-free worker scheduler.
// Input channel (in_valid/in_ready, job_duration): one beat per job.
// Output channel (out_valid/out_ready, worker_id, start_time): one beat per
// job, giving the worker with the earliest free time (lowest id on a tie) and
// the time the job starts there. That worker's free time then advances by the
// duration, saturating at the maximum 48-bit time.
// Config channel (cfg_valid/cfg_ready, cfg_data): workers_in_use, always ready;
// write it only while no job is in flight. 0 acts as 1, values above
// NUM_WORKERS act as NUM_WORKERS.
// Free times live in a single-port memory read one entry per cycle. With N the
// clamped worker count, a job runs a serial scan through entries 0 to N - 1:
// each read is registered, then compared in the min tracker; the winner's entry
// is written back and the result registered; only then is a new job taken.
// Reset clears the memory entry by entry, during which no job is accepted. A
// result waiting on a stalled receiver holds the next job in its write-back
// step until the output register frees up.
module earliest_free_worker_scheduler #(
	parameter int NUM_WORKERS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ewfs_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ewfs_pkg::DUR_W-1:0]    job_duration,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ewfs_pkg::ID_W-1:0]     worker_id,
	output logic      [ewfs_pkg::TIME_W-1:0]   start_time
);

	localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam logic [IDX_W-1:0] LAST_WORKER = IDX_W'(NUM_WORKERS - 1);

	ewfs_pkg::state_t state_q;

	logic [ewfs_pkg::CFG_W-1:0]  workers_q;
	logic [IDX_W-1:0]            last_idx;
	logic [IDX_W-1:0]            clr_q;
	logic [IDX_W-1:0]            rd_addr_q;
	logic                        issue_done_q;
	logic                        pend_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [ewfs_pkg::TIME_W-1:0] rdata_s1;
	logic [ewfs_pkg::DUR_W-1:0]  dur_q;
	logic                        out_valid_q;
	logic [ewfs_pkg::ID_W-1:0]   worker_id_q;
	logic [ewfs_pkg::TIME_W-1:0] start_time_q;

	logic [ewfs_pkg::TIME_W-1:0] mem [NUM_WORKERS];
	logic                        mem_re;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [ewfs_pkg::TIME_W-1:0] mem_wdata;

	logic [IDX_W-1:0]            best_id;
	logic [ewfs_pkg::TIME_W-1:0] best_time;
	logic [ewfs_pkg::TIME_W:0]   sum;
	logic [ewfs_pkg::TIME_W-1:0] next_free;
	logic                        wb_go;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ewfs_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign worker_id  = worker_id_q;
	assign start_time = start_time_q;

	always_comb begin
		if (workers_q == '0) begin
			last_idx = '0;
		end else if (32'(workers_q) >= NUM_WORKERS) begin
			last_idx = LAST_WORKER;
		end else begin
			last_idx = IDX_W'(workers_q - 5'd1);
		end
	end

	assign sum       = {1'b0, best_time} + (ewfs_pkg::TIME_W + 1)'(dur_q);
	assign next_free = sum[ewfs_pkg::TIME_W] ? '1 : sum[ewfs_pkg::TIME_W-1:0];
	assign wb_go     = (state_q == ewfs_pkg::ST_WRITE) && (!out_valid_q || out_ready);
	assign mem_re    = (state_q == ewfs_pkg::ST_SCAN) && !issue_done_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		case (state_q)
			ewfs_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ewfs_pkg::ST_WRITE: begin
				mem_we    = wb_go;
				mem_waddr = best_id;
				mem_wdata = next_free;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[rd_addr_q];
		end
	end

	ewfs_min_track #(
		.IDX_W(IDX_W)
	) u_min (
		.clk       (clk),
		.sample    (pend_s1),
		.idx       (idx_s1),
		.free_time (rdata_s1),
		.best_id   (best_id),
		.best_time (best_time)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			workers_q <= ewfs_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			workers_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ewfs_pkg::ST_CLEAR;
			clr_q        <= '0;
			rd_addr_q    <= '0;
			issue_done_q <= 1'b0;
			pend_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			pend_s1 <= mem_re;
			if (wb_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ewfs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_WORKER) begin
						state_q <= ewfs_pkg::ST_IDLE;
					end
				end
				ewfs_pkg::ST_IDLE: begin
					if (in_valid) begin
						rd_addr_q    <= '0;
						issue_done_q <= 1'b0;
						state_q      <= ewfs_pkg::ST_SCAN;
					end
				end
				ewfs_pkg::ST_SCAN: begin
					if (mem_re) begin
						rd_addr_q <= rd_addr_q + 1'b1;
						if (rd_addr_q == last_idx) begin
							issue_done_q <= 1'b1;
						end
					end
					if (pend_s1 && idx_s1 == last_idx) begin
						state_q <= ewfs_pkg::ST_WRITE;
					end
				end
				ewfs_pkg::ST_WRITE: begin
					if (wb_go) begin
						state_q <= ewfs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ewfs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dur_q <= job_duration;
		end
		if (mem_re) begin
			idx_s1 <= rd_addr_q;
		end
		if (wb_go) begin
			worker_id_q  <= ewfs_pkg::ID_W'(best_id);
			start_time_q <= best_time;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ewfs_min_track.sv -----
`default_nettype none

module ewfs_min_track #(
	parameter int IDX_W = 4
) (
	input  wire logic                          clk,
	input  wire logic                          sample,
	input  wire logic [IDX_W-1:0]              idx,
	input  wire logic [ewfs_pkg::TIME_W-1:0]   free_time,
	output logic      [IDX_W-1:0]              best_id,
	output logic      [ewfs_pkg::TIME_W-1:0]   best_time
);

	logic [IDX_W-1:0]            best_id_q;
	logic [ewfs_pkg::TIME_W-1:0] best_time_q;
	logic                        take;

	// first worker seeds the scan; strict less-than keeps the lowest id on a tie
	assign take = (idx == '0) || (free_time < best_time_q);

	always_ff @(posedge clk) begin
		if (sample && take) begin
			best_id_q   <= idx;
			best_time_q <= free_time;
		end
	end

	assign best_id   = best_id_q;
	assign best_time = best_time_q;

endmodule

`default_nettype wire

// ----- test/earliest_free_worker_scheduler_test.sv -----
`default_nettype none

module earliest_free_worker_scheduler_test;

	localparam int NUM_WORKERS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;
	localparam logic [ewfs_pkg::TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [ewfs_pkg::ID_W-1:0]   id;
		logic [ewfs_pkg::TIME_W-1:0] start;
	} assignment_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [ewfs_pkg::CFG_W-1:0]    cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [ewfs_pkg::DUR_W-1:0]    job_duration = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ewfs_pkg::ID_W-1:0]     worker_id;
	logic [ewfs_pkg::TIME_W-1:0]   start_time;

	logic [ewfs_pkg::DUR_W-1:0]    pending_jobs[$];
	assignment_t                   expected_assignments[$];
	logic [ewfs_pkg::TIME_W-1:0]   free_time_model[NUM_WORKERS];
	logic [ewfs_pkg::CFG_W-1:0]    worker_count_model = ewfs_pkg::CFG_RESET;

	logic                in_taken = 1'b0;
	bit                  no_idle = 1'b0;
	int                  send_gap = 0;
	int                  recv_stall = 0;
	int                  hold_left = 0;
	int                  hold_requests = 0;
	int                  hold_served = 0;
	int                  failures = 0;
	int                  cycles = 0;

	earliest_free_worker_scheduler #(
		.NUM_WORKERS(NUM_WORKERS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.job_duration(job_duration),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.worker_id   (worker_id),
		.start_time  (start_time)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic assignment_t pick_worker(input logic [ewfs_pkg::DUR_W-1:0] dur);
		int                          count;
		int                          best;
		logic [ewfs_pkg::TIME_W:0]   sum;
		assignment_t                 result;
		count = worker_count_model;
		if (count == 0) begin
			count = 1;
		end
		if (count > NUM_WORKERS) begin
			count = NUM_WORKERS;
		end
		best = 0;
		for (int i = 1; i < count; i++) begin
			if (free_time_model[i] < free_time_model[best]) begin
				best = i;
			end
		end
		result.id = best[ewfs_pkg::ID_W-1:0];
		result.start = free_time_model[best];
		sum = {1'b0, free_time_model[best]}
			+ {{(ewfs_pkg::TIME_W+1-ewfs_pkg::DUR_W){1'b0}}, dur};
		free_time_model[best] = sum[ewfs_pkg::TIME_W] ? TIME_MAX : sum[ewfs_pkg::TIME_W-1:0];
		return result;
	endfunction

	task automatic report_miss(input assignment_t want, input bit have_want);
		failures++;
		if (failures <= 10) begin
			if (have_want) begin
				$display("mismatch: expected id %0d start %0d, got id %0d start %0d",
					want.id, want.start, worker_id, start_time);
			end else begin
				$display("unexpected beat: id %0d start %0d", worker_id, start_time);
			end
		end
	endtask

	always @(posedge clk) begin
		assignment_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (cfg_valid && cfg_ready) begin
				worker_count_model = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_assignments.size() == 0) begin
					report_miss(want, 1'b0);
				end else begin
					want = expected_assignments.pop_front();
					if (worker_id !== want.id || start_time !== want.start) begin
						report_miss(want, 1'b1);
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_assignments.push_back(pick_worker(job_duration));
			end
		end
	end

	always @(negedge clk) begin
		if (!(in_valid && !in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_jobs.size() > 0) begin
				job_duration <= pending_jobs.pop_front();
				in_valid <= 1'b1;
				if (!no_idle && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 13);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 5) == 0) begin
				recv_stall = $urandom_range(1, 13);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL earliest_free_worker_scheduler");
			$finish;
		end
	end

	task automatic drain();
		while (pending_jobs.size() != 0 || in_valid || expected_assignments.size() != 0) begin
			@(posedge clk);
		end
		repeat (NUM_WORKERS + 8) @(posedge clk);
	endtask

	task automatic write_worker_count(input logic [ewfs_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	logic [ewfs_pkg::CFG_W-1:0] phase_counts[10];
	int                         sel;
	logic [ewfs_pkg::DUR_W-1:0] dur;

	initial begin
		for (int i = 0; i < NUM_WORKERS; i++) begin
			free_time_model[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_jobs = '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd5, 32'd5, 32'd0};
		drain();
		write_worker_count(5'd0);
		pending_jobs = '{32'd7, 32'd0, 32'd3};
		drain();
		write_worker_count(5'd31);
		pending_jobs = '{32'd2, 32'd0, 32'hFFFF_FFFF};
		drain();
		write_worker_count(5'd17);
		pending_jobs = '{32'd1, 32'd9};
		drain();
		write_worker_count(5'd3);
		pending_jobs = '{32'd4, 32'd4};
		drain();

		phase_counts = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8,
			5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 5'd2};
		for (int p = 0; p < 11; p++) begin
			if (p == 10) begin
				no_idle = 1'b1;
				write_worker_count(5'd16);
			end else begin
				write_worker_count(phase_counts[p]);
			end
			if (p == 3) begin
				hold_requests++;
			end
			for (int i = 0; i < (p == 10 ? 50 : 100); i++) begin
				sel = $urandom_range(0, 9);
				case (sel)
					0: dur = '0;
					1: dur = '1;
					2, 3, 4: dur = $urandom_range(0, 15);
					5, 6: dur = $urandom_range(0, 1000);
					default: dur = $urandom;
				endcase
				pending_jobs.push_back(dur);
			end
			drain();
		end

		if (expected_assignments.size() != 0) begin
			failures++;
		end
		if (failures == 0) begin
			$display("PASS earliest_free_worker_scheduler");
		end else begin
			$display("FAIL earliest_free_worker_scheduler");
		end
		$finish;
	end

endmodule

`default_nettype wire
